>>> sv/cpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared types and codes for the clock page replacer.
// ----------------------------------------------------------------------------
package cpr_pkg;

    // number of physical pages; page numbers fit the 6-bit page field
    localparam int PAGES = 64;

    localparam logic [2:0] ACT_ACTIVATE  = 3'd0;
    localparam logic [2:0] ACT_FREE      = 3'd1;
    localparam logic [2:0] ACT_GET_FREE  = 3'd2;
    localparam logic [2:0] ACT_EVICT     = 3'd3;
    localparam logic [2:0] ACT_REFERENCE = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOFREE   = 2'd1;
    localparam logic [1:0] ST_NOACTIVE = 2'd2;

    typedef struct packed {
        logic [2:0] action;
        logic [5:0] page;
    } cpr_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] page_out;
    } cpr_out_t;

endpackage

>>> sv/clock_page_replacement.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_page_replacement
// Second-chance clock replacer: circular active list, free FIFO and
// referenced bits in synchronous memories.
// ----------------------------------------------------------------------------
// Sequencing: activate/reference/errors/unused codes go straight to the result;
// get-free reads the free queue head and appends it to the active list; free
// reads and checks each active entry, then compacts behind the match by a read
// and a write per entry moved; evict moves each visited front page to the back.
// One transaction at a time; a result waits in the output register and the
// next input is taken the cycle after it is accepted.
// Reset: list empty; the free queue is filled with pages 1..PAGES-1 and all
// referenced bits are cleared by a sweep over all entries before the first input.
module clock_page_replacement (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cpr_pkg::cpr_in_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output cpr_pkg::cpr_out_t  out_data
);

    localparam int AW = $clog2(cpr_pkg::PAGES);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] FULL = CW'(cpr_pkg::PAGES);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_GETRD  = 4'd2;
    localparam logic [3:0] S_GETWR  = 4'd3;
    localparam logic [3:0] S_EVRD   = 4'd4;
    localparam logic [3:0] S_EVCHK  = 4'd5;
    localparam logic [3:0] S_FRRD   = 4'd6;
    localparam logic [3:0] S_FRCHK  = 4'd7;
    localparam logic [3:0] S_SHRD   = 4'd8;
    localparam logic [3:0] S_SHWR   = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;
    localparam logic [3:0] S_EVREF  = 4'd11;

    // Active list is a ring: logical index i lives at act_head + i.
    logic [5:0] act_mem [cpr_pkg::PAGES];
    logic [5:0] free_mem [cpr_pkg::PAGES];
    logic       ref_mem [cpr_pkg::PAGES];
    logic [5:0] act_rd_reg, free_rd_reg;
    logic       ref_rd_reg;

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] act_head_reg, act_head_next;
    logic [CW-1:0] act_cnt_reg, act_cnt_next;
    logic [AW-1:0] free_head_reg, free_head_next;
    logic [CW-1:0] free_cnt_reg, free_cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    cpr_pkg::cpr_in_t  req_reg, req_next;
    cpr_pkg::cpr_out_t res_reg, res_next;

    logic          act_we, act_re, free_we, free_re, ref_we, ref_re;
    logic [AW-1:0] act_wa, act_ra, free_wa, free_ra, ref_wa, ref_ra;
    logic [5:0]    act_wd, free_wd;
    logic          ref_wd;

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = (state_reg == S_OUT);
    assign out_data   = res_reg;

    // Memories
    always_ff @(posedge clk)
    begin
        if (act_we)
        begin
            act_mem[act_wa] <= act_wd;
        end
        if (act_re)
        begin
            act_rd_reg <= act_mem[act_ra];
        end
        if (free_we)
        begin
            free_mem[free_wa] <= free_wd;
        end
        if (free_re)
        begin
            free_rd_reg <= free_mem[free_ra];
        end
        if (ref_we)
        begin
            ref_mem[ref_wa] <= ref_wd;
        end
        if (ref_re)
        begin
            ref_rd_reg <= ref_mem[ref_ra];
        end
    end

    // Control sequencer
    always_comb
    begin
        state_next     = state_reg;
        act_head_next  = act_head_reg;
        act_cnt_next   = act_cnt_reg;
        free_head_next = free_head_reg;
        free_cnt_next  = free_cnt_reg;
        idx_next       = idx_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        act_we = 1'b0; act_re = 1'b0; free_we = 1'b0; free_re = 1'b0;
        act_wa = '0; act_ra = '0; free_wa = '0; free_ra = '0;
        act_wd = '0; free_wd = '0;
        ref_we = 1'b0; ref_re = 1'b0; ref_wa = '0; ref_ra = '0; ref_wd = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                // fill free queue: entry i holds page i+1 (last entry 0); clear bit i
                free_we  = 1'b1;
                free_wa  = idx_reg[AW-1:0];
                free_wd  = (idx_reg + 1'b1 < FULL) ? 6'(idx_reg + 1'b1) : 6'd0;
                ref_we   = 1'b1;
                ref_wa   = idx_reg[AW-1:0];
                ref_wd   = 1'b0;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == FULL - 1'b1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = in_data;
                    res_next   = '{status: cpr_pkg::ST_OK, page_out: 6'd0};
                    state_next = S_OUT;
                    idx_next   = '0;
                    unique case (in_data.action)
                        cpr_pkg::ACT_ACTIVATE:
                        begin
                            if ((CW'(in_data.page) < FULL) && act_cnt_reg < FULL)
                            begin
                                act_we        = 1'b1;
                                act_wa        = act_head_reg - 1'b1;
                                act_wd        = in_data.page;
                                act_head_next = act_head_reg - 1'b1;
                                act_cnt_next  = act_cnt_reg + 1'b1;
                            end
                        end
                        cpr_pkg::ACT_FREE:
                        begin
                            if (CW'(in_data.page) < FULL && act_cnt_reg != '0)
                            begin
                                state_next = S_FRRD;
                            end
                        end
                        cpr_pkg::ACT_GET_FREE:
                        begin
                            if (free_cnt_reg == '0)
                            begin
                                res_next.status = cpr_pkg::ST_NOFREE;
                            end
                            else
                            begin
                                free_re    = 1'b1;
                                free_ra    = free_head_reg;
                                state_next = S_GETRD;
                            end
                        end
                        cpr_pkg::ACT_EVICT:
                        begin
                            if (act_cnt_reg == '0)
                            begin
                                res_next.status = cpr_pkg::ST_NOACTIVE;
                            end
                            else
                            begin
                                state_next = S_EVRD;
                            end
                        end
                        cpr_pkg::ACT_REFERENCE:
                        begin
                            if (CW'(in_data.page) < FULL)
                            begin
                                ref_we = 1'b1;
                                ref_wa = in_data.page[AW-1:0];
                                ref_wd = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_GETRD:
            begin
                state_next = S_GETWR;
            end
            S_GETWR:
            begin
                res_next.page_out = free_rd_reg;
                free_head_next    = free_head_reg + 1'b1;
                free_cnt_next     = free_cnt_reg - 1'b1;
                if (act_cnt_reg < FULL)
                begin
                    act_we       = 1'b1;
                    act_wa       = act_head_reg + act_cnt_reg[AW-1:0];
                    act_wd       = free_rd_reg;
                    act_cnt_next = act_cnt_reg + 1'b1;
                end
                state_next = S_OUT;
            end
            S_EVRD:
            begin
                // read the front entry
                act_re     = 1'b1;
                act_ra     = act_head_reg;
                state_next = S_EVCHK;
            end
            S_EVCHK:
            begin
                // front moves to back: copy it past the last entry, advance
                // head, and fetch its referenced bit
                act_we        = 1'b1;
                act_wa        = act_head_reg + act_cnt_reg[AW-1:0];
                act_wd        = act_rd_reg;
                act_head_next = act_head_reg + 1'b1;
                ref_re        = 1'b1;
                ref_ra        = act_rd_reg[AW-1:0];
                state_next    = S_EVREF;
            end
            S_EVREF:
            begin
                // referenced: clear and keep sweeping; else it is the victim
                if (ref_rd_reg)
                begin
                    ref_we     = 1'b1;
                    ref_wa     = act_rd_reg[AW-1:0];
                    ref_wd     = 1'b0;
                    state_next = S_EVRD;
                end
                else
                begin
                    res_next.page_out = act_rd_reg;
                    state_next        = S_OUT;
                end
            end
            S_FRRD:
            begin
                act_re     = 1'b1;
                act_ra     = act_head_reg + idx_reg[AW-1:0];
                state_next = S_FRCHK;
            end
            S_FRCHK:
            begin
                if (act_rd_reg == req_reg.page)
                begin
                    ref_we = 1'b1;
                    ref_wa = req_reg.page[AW-1:0];
                    ref_wd = 1'b0;
                    if (free_cnt_reg < FULL)
                    begin
                        free_we       = 1'b1;
                        free_wa       = free_head_reg + free_cnt_reg[AW-1:0];
                        free_wd       = req_reg.page;
                        free_cnt_next = free_cnt_reg + 1'b1;
                    end
                    state_next = S_SHRD;
                end
                else if (idx_reg + 1'b1 >= act_cnt_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_FRRD;
                end
            end
            S_SHRD:
            begin
                // close the gap: entry idx takes entry idx+1
                if (idx_reg + 1'b1 >= act_cnt_reg)
                begin
                    act_cnt_next = act_cnt_reg - 1'b1;
                    state_next   = S_OUT;
                end
                else
                begin
                    act_re     = 1'b1;
                    act_ra     = act_head_reg + idx_reg[AW-1:0] + 1'b1;
                    state_next = S_SHWR;
                end
            end
            S_SHWR:
            begin
                act_we     = 1'b1;
                act_wa     = act_head_reg + idx_reg[AW-1:0];
                act_wd     = act_rd_reg;
                idx_next   = idx_reg + 1'b1;
                state_next = S_SHRD;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            act_head_reg  <= '0;
            act_cnt_reg   <= '0;
            free_head_reg <= '0;
            free_cnt_reg  <= FULL - 1'b1;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            act_head_reg  <= act_head_next;
            act_cnt_reg   <= act_cnt_next;
            free_head_reg <= free_head_next;
            free_cnt_reg  <= free_cnt_next;
            idx_reg       <= idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        res_reg <= res_next;
    end

    // Checks
    a_act_bound: assert property (@(posedge clk) disable iff (!rst_n)
        act_cnt_reg <= FULL) else $error("active count overflow");
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_cnt_reg <= FULL) else $error("free count overflow");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result dropped");
    a_evict_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVRD) |-> (act_cnt_reg != '0)) else $error("evict on empty");

endmodule
